// ----- rtl/fsnw_pkg.sv -----
// Shared types, codes and constant tables for the FM synth note register writer.
// No dependencies; every other file in rtl/ imports this package.
package fsnw_pkg;

  // Command codes on the request channel
  localparam logic [1:0] CMD_NOTE_ON  = 2'd0;
  localparam logic [1:0] CMD_NOTE_OFF = 2'd1;
  localparam logic [1:0] CMD_RESET    = 2'd2;

  localparam int PATCH_COUNT_DEFAULT = 6;
  localparam int ROM_PATCHES         = 6;
  localparam int PATCH_BYTES         = 11;
  localparam int NUM_CHANNELS        = 9;
  localparam int QUEUE_DEPTH         = 2;

  localparam int NOTE_ON_WRITES  = 14;
  localparam int NOTE_OFF_WRITES = 1;
  localparam int RESET_WRITES    = 11;

  typedef enum logic [1:0] {
    KIND_NOTE_ON,
    KIND_NOTE_OFF,
    KIND_RESET
  } cmd_kind_t;

  // One classified request, ready for the write sequencer
  typedef struct packed {
    cmd_kind_t   kind;
    logic [3:0]  ch;
    logic [4:0]  op;      // modulator operator offset
    logic [2:0]  patch;
    logic [5:0]  level;   // velocity-scaled carrier attenuation
    logic [9:0]  fnum;
    logic [2:0]  block;
  } desc_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } enq_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Per patch: modulator 20,40,60,80,E0; carrier 20,40,60,80,E0; feedback
  localparam logic [7:0] PATCH_ROM [ROM_PATCHES][PATCH_BYTES] = '{
    '{8'h21, 8'h22, 8'hF2, 8'h73, 8'h00, 8'h01, 8'h08, 8'hF4, 8'h36, 8'h00, 8'h06},
    '{8'h01, 8'h18, 8'hA4, 8'h74, 8'h00, 8'h01, 8'h10, 8'hA4, 8'h74, 8'h00, 8'h04},
    '{8'h21, 8'h12, 8'hF3, 8'h45, 8'h00, 8'h01, 8'h08, 8'hF2, 8'h35, 8'h00, 8'h02},
    '{8'h01, 8'h16, 8'hF8, 8'h08, 8'h00, 8'h01, 8'h08, 8'hF8, 8'h08, 8'h00, 8'h0E},
    '{8'h01, 8'h10, 8'hF6, 8'h16, 8'h00, 8'h01, 8'h06, 8'hF3, 8'h08, 8'h00, 8'h0F},
    '{8'h01, 8'h18, 8'hF2, 8'h04, 8'h00, 8'h01, 8'h0A, 8'hF1, 8'h03, 8'h00, 8'h0F}
  };

  // Index of the carrier level byte within a patch
  localparam int PATCH_CAR_LEVEL = 6;
  localparam int PATCH_FEEDBACK  = 10;

  localparam logic [4:0] OP_OFFSET [NUM_CHANNELS] = '{
    5'd0, 5'd1, 5'd2, 5'd8, 5'd9, 5'd10, 5'd16, 5'd17, 5'd18
  };

  localparam logic [9:0] FNUM_ROM [12] = '{
    10'd343, 10'd363, 10'd385, 10'd408, 10'd432, 10'd458,
    10'd485, 10'd514, 10'd544, 10'd577, 10'd611, 10'd647
  };

  // Operator register bases for the ten patch writes (modulator then carrier)
  localparam logic [7:0] OPERATOR_REG [10] = '{
    8'h20, 8'h40, 8'h60, 8'h80, 8'hE0, 8'h20, 8'h40, 8'h60, 8'h80, 8'hE0
  };

  localparam logic [7:0] REG_TEST_CTRL  = 8'h01;
  localparam logic [7:0] VAL_WAVE_EN    = 8'h20;
  localparam logic [7:0] REG_FNUM_LO    = 8'hA0;
  localparam logic [7:0] REG_KEY_BLOCK  = 8'hB0;
  localparam logic [7:0] REG_RHYTHM     = 8'hBD;
  localparam logic [7:0] REG_FEEDBACK   = 8'hC0;
  localparam logic [7:0] KEY_ON_BIT     = 8'h20;

endpackage

// ----- rtl/fm_synth_note_register_writer.sv -----
// FM synth note register writer: turns note on / note off / reset requests
// into runs of synth register writes, one write per cycle unless the sink
// stalls with wr_ready low. A note on gives 14 writes, reset 11, note off 1.
// Sync reset empties queue and output.
module fm_synth_note_register_writer #(
  parameter int PATCH_COUNT = fsnw_pkg::PATCH_COUNT_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  logic [1:0] command,
  input  logic [3:0] channel,
  input  logic [6:0] note,
  input  logic [7:0] instrument,
  input  logic [6:0] velocity,
  output logic       wr_valid,
  input  logic       wr_ready,
  output logic [7:0] register_address,
  output logic [7:0] register_value,
  output logic       last_write
);
  import fsnw_pkg::*;

  enq_t      enq;
  desc_t     head;
  q_status_t q_status;
  logic      pop;

  // Front end: classify each request, drop those that give no writes,
  // precompute patch index, fnum, block and carrier level.
  fsnw_front #(
    .PATCH_COUNT(PATCH_COUNT)
  ) u_front (
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .command   (command),
    .channel   (channel),
    .note      (note),
    .instrument(instrument),
    .velocity  (velocity),
    .q_status  (q_status),
    .enq       (enq)
  );

  // Hold classified requests so the front keeps accepting while the
  // sequencer works through a long run or the sink stalls.
  fsnw_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .enq   (enq),
    .pop   (pop),
    .head  (head),
    .status(q_status)
  );

  // Back end: advance through the writes of the head request, drop it from
  // the queue with its last write.
  fsnw_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .q_status        (q_status),
    .pop             (pop),
    .wr_valid        (wr_valid),
    .wr_ready        (wr_ready),
    .register_address(register_address),
    .register_value  (register_value),
    .last_write      (last_write)
  );

  // The queue never takes a request while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    enq.valid |-> !q_status.full)
    else $error("request pushed into a full queue");

  // A request leaves the queue only if one is there
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("request popped from an empty queue");

  // Completing a run frees a slot, so the front is ready next cycle
  a_pop_frees: assert property (@(posedge clk) disable iff (rst)
    pop && !enq.valid |=> cmd_ready)
    else $error("queue still full after a run completed");

endmodule

// ----- rtl/fsnw_front.sv -----
// Request front end: accepts commands, drops those that give no writes,
// looks up patch, frequency and level, and pushes a descriptor. Uses fsnw_pkg.
module fsnw_front #(
  parameter int PATCH_COUNT = fsnw_pkg::PATCH_COUNT_DEFAULT
) (
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  logic [1:0]            command,
  input  logic [3:0]            channel,
  input  logic [6:0]            note,
  input  logic [7:0]            instrument,
  input  logic [6:0]            velocity,
  input  fsnw_pkg::q_status_t   q_status,
  output fsnw_pkg::enq_t        enq
);
  import fsnw_pkg::*;

  logic [2:0] patch_lut [256];
  logic [3:0] note_semi [128];
  logic [2:0] note_blk  [128];

  // Constant lookup tables, folded at elaboration
  for (genvar g = 0; g < 256; g++) begin : g_patch
    assign patch_lut[g] = 3'((g % PATCH_COUNT) % ROM_PATCHES);
  end

  for (genvar g = 0; g < 128; g++) begin : g_note
    localparam int Oct = g / 12;
    assign note_semi[g] = 4'(g % 12);
    assign note_blk[g]  = (Oct == 0) ? 3'd0 : (Oct > 8) ? 3'd7 : 3'(Oct - 1);
  end

  logic       ch_ok;
  logic       note_ok;
  logic       produce;
  cmd_kind_t  kind;
  logic [2:0] patch;
  logic [7:0] car_level;
  logic [6:0] vel_n;
  logic [6:0] level_sum;

  assign cmd_ready = !q_status.full;

  assign ch_ok   = channel < 4'(NUM_CHANNELS);
  assign note_ok = note >= 7'd12;
  assign patch   = patch_lut[instrument];

  assign car_level = PATCH_ROM[patch][PATCH_CAR_LEVEL];
  assign vel_n     = ~velocity;
  assign level_sum = {1'b0, car_level[5:0]} + {2'b00, vel_n[6:2]};

  always_comb begin
    produce = 1'b0;
    kind    = KIND_NOTE_ON;
    unique case (command)
      CMD_NOTE_ON: begin
        produce = ch_ok && note_ok;
        kind    = KIND_NOTE_ON;
      end
      CMD_NOTE_OFF: begin
        produce = ch_ok;
        kind    = KIND_NOTE_OFF;
      end
      CMD_RESET: begin
        produce = 1'b1;
        kind    = KIND_RESET;
      end
      default: produce = 1'b0;
    endcase
  end

  always_comb begin
    enq.valid      = cmd_valid && cmd_ready && produce;
    enq.desc.kind  = kind;
    enq.desc.ch    = channel;
    enq.desc.op    = ch_ok ? OP_OFFSET[channel] : 5'd0;
    enq.desc.patch = patch;
    enq.desc.level = level_sum[6] ? 6'h3F : level_sum[5:0];
    enq.desc.fnum  = FNUM_ROM[note_semi[note]];
    enq.desc.block = note_blk[note];
  end

endmodule

// ----- rtl/fsnw_queue.sv -----
// Short descriptor queue between front end and write sequencer.
// Uses fsnw_pkg for the descriptor and status types.
module fsnw_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  fsnw_pkg::enq_t       enq,
  input  logic                 pop,
  output fsnw_pkg::desc_t      head,
  output fsnw_pkg::q_status_t  status
);
  import fsnw_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  desc_t           mem [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign head         = mem[rd_ptr];
  assign status.full  = count == CntW'(QUEUE_DEPTH);
  assign status.empty = count == '0;

  always_ff @(posedge clk) begin
    if (enq.valid) begin
      mem[wr_ptr] <= enq.desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq.valid) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({enq.valid, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/fsnw_back.sv -----
// Write sequencer: steps through the register writes of the queue head,
// one per cycle while wr_ready allows, into the output register. Uses fsnw_pkg.
module fsnw_back (
  input  logic                 clk,
  input  logic                 rst,
  input  fsnw_pkg::desc_t      head,
  input  fsnw_pkg::q_status_t  q_status,
  output logic                 pop,
  output logic                 wr_valid,
  input  logic                 wr_ready,
  output logic [7:0]           register_address,
  output logic [7:0]           register_value,
  output logic                 last_write
);
  import fsnw_pkg::*;

  localparam logic [3:0] STEP_FIRST_PATCH = 4'd1;
  localparam logic [3:0] STEP_LAST_PATCH  = 4'd10;
  localparam logic [3:0] STEP_FEEDBACK    = 4'd11;
  localparam logic [3:0] STEP_FNUM        = 4'd12;
  localparam logic [3:0] STEP_KEY_ON      = 4'(NOTE_ON_WRITES - 1);
  localparam logic [3:0] STEP_CTRL        = 4'(RESET_WRITES - 2);
  localparam logic [3:0] STEP_RHYTHM      = 4'(RESET_WRITES - 1);
  localparam logic [3:0] CAR_LEVEL_IDX    = 4'(PATCH_CAR_LEVEL);
  localparam logic [3:0] FIRST_CARRIER    = 4'd5;

  logic [3:0] step;
  logic [3:0] step_next;
  logic       load;
  logic [3:0] idx;
  logic [4:0] op_sel;
  logic [7:0] patch_byte;
  logic [7:0] addr_c;
  logic [7:0] val_c;
  logic       last_c;

  assign load = !q_status.empty && (!wr_valid || wr_ready);
  assign pop  = load && last_c;
  assign step_next = last_c ? 4'd0 : step + 4'd1;

  assign idx        = step - STEP_FIRST_PATCH;
  assign op_sel     = (idx >= FIRST_CARRIER) ? head.op + 5'd3 : head.op;
  assign patch_byte = PATCH_ROM[head.patch][idx];

  always_comb begin
    addr_c = REG_KEY_BLOCK + {4'b0, head.ch};
    val_c  = 8'h00;
    last_c = 1'b0;
    unique case (head.kind)
      KIND_NOTE_ON: begin
        last_c = step == STEP_KEY_ON;
        if (step >= STEP_FIRST_PATCH && step <= STEP_LAST_PATCH) begin
          addr_c = OPERATOR_REG[idx] + {3'b0, op_sel};
          val_c  = (idx == CAR_LEVEL_IDX) ? {patch_byte[7:6], head.level} : patch_byte;
        end else if (step == STEP_FEEDBACK) begin
          addr_c = REG_FEEDBACK + {4'b0, head.ch};
          val_c  = PATCH_ROM[head.patch][PATCH_FEEDBACK];
        end else if (step == STEP_FNUM) begin
          addr_c = REG_FNUM_LO + {4'b0, head.ch};
          val_c  = head.fnum[7:0];
        end else if (step == STEP_KEY_ON) begin
          val_c = KEY_ON_BIT | {3'b0, head.block, head.fnum[9:8]};
        end
      end
      KIND_NOTE_OFF: begin
        last_c = 1'b1;
      end
      KIND_RESET: begin
        last_c = step == STEP_RHYTHM;
        if (step == STEP_CTRL) begin
          addr_c = REG_TEST_CTRL;
          val_c  = VAL_WAVE_EN;
        end else if (step == STEP_RHYTHM) begin
          addr_c = REG_RHYTHM;
        end else begin
          addr_c = REG_KEY_BLOCK + {4'b0, step};
        end
      end
      default: last_c = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= '0;
      wr_valid <= 1'b0;
    end else begin
      if (load) begin
        step     <= step_next;
        wr_valid <= 1'b1;
      end else if (wr_ready) begin
        wr_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      register_address <= addr_c;
      register_value   <= val_c;
      last_write       <= last_c;
    end
  end

endmodule
